// ----- hdl/tlcp_pkg.sv -----
`default_nettype none

package tlcp_pkg;

    // Working width of signed coordinates and translated label bounds
    localparam int SW = 16;

    typedef logic signed [SW-1:0] coord_t;

    typedef struct packed {
        coord_t lx;
        coord_t rx;
        coord_t ly;
        coord_t ry;
    } box_t;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_BOUND   = 10'b00_0000_0010,
        ST_RANGE   = 10'b00_0000_0100,
        ST_CNT_RD  = 10'b00_0000_1000,
        ST_CNT_CHK = 10'b00_0001_0000,
        ST_ENT_RD  = 10'b00_0010_0000,
        ST_ENT_CMP = 10'b00_0100_0000,
        ST_WCNT_RD = 10'b00_1000_0000,
        ST_WCNT_WR = 10'b01_0000_0000,
        ST_DONE    = 10'b10_0000_0000
    } state_t;

    localparam logic [2:0] STAT_PLACED  = 3'd0;
    localparam logic [2:0] STAT_OVERLAP = 3'd1;
    localparam logic [2:0] STAT_OUT     = 3'd2;
    localparam logic [2:0] STAT_ZERO    = 3'd3;
    localparam logic [2:0] STAT_FULL    = 3'd4;
    localparam logic [2:0] STAT_CLEARED = 3'd5;

    localparam logic [2:0] CFG_VIEW_X0     = 3'd0;
    localparam logic [2:0] CFG_VIEW_Y0     = 3'd1;
    localparam logic [2:0] CFG_VIEW_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_VIEW_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_MARKER_SIZE = 3'd4;
    localparam logic [2:0] CFG_PLACE_ALL   = 3'd5;

endpackage

`default_nettype wire

// ----- hdl/tiled_label_collision_placer.sv -----
`default_nettype none

// Tiled label placer: each place item builds a square label of side
// 2*floor(marker_size/2) around its anchor, culls it against the viewport
// (touching edges count as inside), bins it into the screen tiles it covers
// and accepts it only if it strictly overlaps no label stored there and no
// covered tile is full, then stores it in every covered tile. Place-all
// accepts any in-view label of nonzero size with no compare or store. A
// new-frame item empties all tiles by clearing their valid bits. One item
// at a time runs through a sequencer around one shared compare unit and two
// memories (fill counts, label entries), each with a write port and a
// registered read port. Per place item: bound and tile-range setup, a fill
// count fetch and a compare of each stored label per covered tile, then a
// count update and label store per tile, then hand-off. Culled, zero-size,
// place-all and new-frame items skip to it. The compare loop sets the rate.
module tiled_label_collision_placer #(
    parameter int TILE_SHIFT    = 7,
    parameter int MAX_TILES_X   = 16,
    parameter int MAX_TILES_Y   = 16,
    parameter int TILE_CAPACITY = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [11:0] cfg_wr_data,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic        s_req_type,
    input  wire logic signed [13:0] s_anchor_x,
    input  wire logic signed [13:0] s_anchor_y,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic        m_placed,
    output      logic [2:0]  m_status
);
    import tlcp_pkg::*;

    localparam int NSLOTS = MAX_TILES_X * MAX_TILES_Y;
    localparam int NENT   = NSLOTS * TILE_CAPACITY;
    localparam int TXW    = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
    localparam int TYW    = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;
    localparam int SLW    = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int AW     = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int KW     = $clog2(TILE_CAPACITY + 1);
    localparam int TSIZE  = 1 << TILE_SHIFT;

    // Configuration registers
    logic [11:0] view_x0_reg, view_y0_reg, view_w_reg, view_h_reg;
    logic [7:0]  marker_reg;
    logic        place_all_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            view_x0_reg   <= '0;
            view_y0_reg   <= '0;
            view_w_reg    <= 12'd2048;
            view_h_reg    <= 12'd2048;
            marker_reg    <= 8'd8;
            place_all_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_VIEW_X0:     view_x0_reg   <= cfg_wr_data;
                CFG_VIEW_Y0:     view_y0_reg   <= cfg_wr_data;
                CFG_VIEW_WIDTH:  view_w_reg    <= cfg_wr_data;
                CFG_VIEW_HEIGHT: view_h_reg    <= cfg_wr_data;
                CFG_MARKER_SIZE: marker_reg    <= cfg_wr_data[7:0];
                CFG_PLACE_ALL:   place_all_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer and working registers
    state_t state_reg, state_next;
    coord_t ax_reg, ay_reg;
    box_t   box_reg;
    logic [TXW-1:0] tx_reg, tx0_reg, tx1_reg;
    logic [TYW-1:0] ty_reg, ty0_reg, ty1_reg;
    logic [KW-1:0]  k_reg, n_reg;
    logic           full_reg;
    logic           res_placed_reg;
    logic [2:0]     res_status_reg;
    logic           m_valid_reg, m_placed_reg;
    logic [2:0]     m_status_reg;

    // Fill-count memory with per-slot valid bits; a cleared slot reads as zero
    logic [KW-1:0]     fcnt_mem [NSLOTS];
    logic [NSLOTS-1:0] slot_vld_reg;
    logic [KW-1:0]     fcnt_q;
    logic              fvld_q;

    // Label entry memory
    box_t ent_mem [NENT];
    box_t ent_q;

    logic [SLW-1:0] slot;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic [KW-1:0]  cur_cnt;

    assign slot    = SLW'(tx_reg) * SLW'(MAX_TILES_Y) + SLW'(ty_reg);
    assign rd_addr = AW'(slot) * AW'(TILE_CAPACITY) + AW'(k_reg);
    assign cur_cnt = fvld_q ? fcnt_q : '0;
    assign wr_addr = AW'(slot) * AW'(TILE_CAPACITY) + AW'(cur_cnt);

    logic s_fire;
    logic out_load;
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Bound stage: square around anchor and viewport cull
    logic [6:0] half;
    coord_t llx, lly, urx, ury, vx0, vy0, vx1, vy1;
    box_t   box_new;
    logic   cull;

    always_comb begin
        half = marker_reg[7:1];
        llx  = ax_reg - coord_t'(half);
        lly  = ay_reg - coord_t'(half);
        urx  = llx + coord_t'({half, 1'b0});
        ury  = lly + coord_t'({half, 1'b0});
        vx0  = coord_t'(view_x0_reg);
        vy0  = coord_t'(view_y0_reg);
        vx1  = vx0 + coord_t'(view_w_reg);
        vy1  = vy0 + coord_t'(view_h_reg);
        cull = (lly > vy1) || (ury < vy0) || (llx > vx1) || (urx < vx0);
        box_new.lx = llx - vx0;
        box_new.rx = urx - vx0;
        box_new.ly = lly - vy0;
        box_new.ry = ury - vy0;
    end

    // Range stage: tile span with floor/ceil, grid size, clamp
    coord_t nx_raw, ny_raw, nx, ny, ftx0, ctx1, fty0, cty1;
    coord_t ctx0, cctx1, ctx0y, ccty1;
    logic   range_out, range_empty;

    always_comb begin
        nx_raw = (coord_t'(view_w_reg) + coord_t'(TSIZE - 1)) >>> TILE_SHIFT;
        ny_raw = (coord_t'(view_h_reg) + coord_t'(TSIZE - 1)) >>> TILE_SHIFT;
        nx     = (nx_raw > coord_t'(MAX_TILES_X)) ? coord_t'(MAX_TILES_X) : nx_raw;
        ny     = (ny_raw > coord_t'(MAX_TILES_Y)) ? coord_t'(MAX_TILES_Y) : ny_raw;
        ftx0   = box_reg.lx >>> TILE_SHIFT;
        ctx1   = (box_reg.rx + coord_t'(TSIZE - 1)) >>> TILE_SHIFT;
        fty0   = box_reg.ly >>> TILE_SHIFT;
        cty1   = (box_reg.ry + coord_t'(TSIZE - 1)) >>> TILE_SHIFT;
        range_out = (ftx0 > nx) || (ctx1 < 0) || (fty0 > ny) || (cty1 < 0);
        ctx0   = (ftx0 < 0) ? '0 : ftx0;
        ctx0y  = (fty0 < 0) ? '0 : fty0;
        cctx1  = (ctx1 >= nx) ? nx - coord_t'(1) : ctx1;
        ccty1  = (cty1 >= ny) ? ny - coord_t'(1) : cty1;
        range_empty = (ctx0 > cctx1) || (ctx0y > ccty1);
    end

    // Shared compare unit: strict overlap of the new label with a stored one
    logic overlap;
    assign overlap = (box_reg.lx < ent_q.rx) && (ent_q.lx < box_reg.rx) &&
                     (box_reg.ly < ent_q.ry) && (ent_q.ly < box_reg.ry);

    logic last_tile;
    assign last_tile = (tx_reg == tx1_reg) && (ty_reg == ty1_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_fire) state_next = s_req_type ? ST_DONE : ST_BOUND;
            ST_BOUND: begin
                if (half == '0 || cull || place_all_reg) state_next = ST_DONE;
                else                                     state_next = ST_RANGE;
            end
            ST_RANGE:   state_next = (range_out || range_empty) ? ST_DONE : ST_CNT_RD;
            ST_CNT_RD:  state_next = ST_CNT_CHK;
            ST_CNT_CHK: begin
                if (cur_cnt != '0)  state_next = ST_ENT_RD;
                else if (!last_tile) state_next = ST_CNT_RD;
                else if (full_reg)  state_next = ST_DONE;
                else                state_next = ST_WCNT_RD;
            end
            ST_ENT_RD:  state_next = ST_ENT_CMP;
            ST_ENT_CMP: begin
                if (overlap)                    state_next = ST_DONE;
                else if (k_reg + 1'b1 < n_reg)  state_next = ST_ENT_RD;
                else if (!last_tile)            state_next = ST_CNT_RD;
                else if (full_reg)              state_next = ST_DONE;
                else                            state_next = ST_WCNT_RD;
            end
            ST_WCNT_RD: state_next = ST_WCNT_WR;
            ST_WCNT_WR: state_next = last_tile ? ST_DONE : ST_WCNT_RD;
            ST_DONE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // Valid bits: clear all on reset or new frame, set on store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
        end else if (s_fire && s_req_type) begin
            slot_vld_reg <= '0;
        end else if (state_reg == ST_WCNT_WR) begin
            slot_vld_reg[slot] <= 1'b1;
        end
    end

    // Memories: registered reads every cycle at the current slot / entry
    always_ff @(posedge aclk) begin
        fcnt_q <= fcnt_mem[slot];
        fvld_q <= slot_vld_reg[slot];
        if (state_reg == ST_WCNT_WR) fcnt_mem[slot] <= cur_cnt + 1'b1;
    end

    always_ff @(posedge aclk) begin
        ent_q <= ent_mem[rd_addr];
        if (state_reg == ST_WCNT_WR) ent_mem[wr_addr] <= box_reg;
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                ax_reg         <= coord_t'(s_anchor_x);
                ay_reg         <= coord_t'(s_anchor_y);
                res_placed_reg <= 1'b0;
                res_status_reg <= STAT_CLEARED;
            end
            ST_BOUND: begin
                box_reg        <= box_new;
                res_placed_reg <= 1'b0;
                if (half == '0) begin
                    res_status_reg <= STAT_ZERO;
                end else if (cull) begin
                    res_status_reg <= STAT_OUT;
                end else begin
                    res_placed_reg <= 1'b1;
                    res_status_reg <= STAT_PLACED;
                end
            end
            ST_RANGE: begin
                tx0_reg  <= TXW'(ctx0);
                tx1_reg  <= TXW'(cctx1);
                ty0_reg  <= TYW'(ctx0y);
                ty1_reg  <= TYW'(ccty1);
                tx_reg   <= TXW'(ctx0);
                ty_reg   <= TYW'(ctx0y);
                full_reg <= 1'b0;
                if (range_out) begin
                    res_placed_reg <= 1'b0;
                    res_status_reg <= STAT_OUT;
                end else begin
                    res_placed_reg <= 1'b1;
                    res_status_reg <= STAT_PLACED;
                end
            end
            ST_CNT_CHK: begin
                n_reg <= cur_cnt;
                k_reg <= '0;
                if (cur_cnt >= KW'(TILE_CAPACITY)) full_reg <= 1'b1;
                if (cur_cnt == '0) begin
                    if (!last_tile) begin
                        if (ty_reg == ty1_reg) begin
                            ty_reg <= ty0_reg;
                            tx_reg <= tx_reg + 1'b1;
                        end else begin
                            ty_reg <= ty_reg + 1'b1;
                        end
                    end else begin
                        tx_reg <= tx0_reg;
                        ty_reg <= ty0_reg;
                        if (full_reg) begin
                            res_placed_reg <= 1'b0;
                            res_status_reg <= STAT_FULL;
                        end
                    end
                end
            end
            ST_ENT_CMP: begin
                k_reg <= k_reg + 1'b1;
                if (overlap) begin
                    res_placed_reg <= 1'b0;
                    res_status_reg <= STAT_OVERLAP;
                end else if (k_reg + 1'b1 >= n_reg) begin
                    if (!last_tile) begin
                        if (ty_reg == ty1_reg) begin
                            ty_reg <= ty0_reg;
                            tx_reg <= tx_reg + 1'b1;
                        end else begin
                            ty_reg <= ty_reg + 1'b1;
                        end
                    end else begin
                        tx_reg <= tx0_reg;
                        ty_reg <= ty0_reg;
                        if (full_reg) begin
                            res_placed_reg <= 1'b0;
                            res_status_reg <= STAT_FULL;
                        end
                    end
                end
            end
            ST_WCNT_WR: begin
                if (!last_tile) begin
                    if (ty_reg == ty1_reg) begin
                        ty_reg <= ty0_reg;
                        tx_reg <= tx_reg + 1'b1;
                    end else begin
                        ty_reg <= ty_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Output register: hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_placed_reg <= res_placed_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_placed = m_placed_reg;
    assign m_status = m_status_reg;

endmodule

`default_nettype wire

// ----- hdl/tlcp_checker.sv -----
`default_nettype none

module tlcp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_placed,
    input wire logic [2:0] m_status
);
    import tlcp_pkg::*;

    // One item at a time: ready drops after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after accept");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= STAT_CLEARED))
        else $error("status code out of range");

    a_placed_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_placed == (m_status == STAT_PLACED)))
        else $error("placed flag disagrees with status");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_placed))
        else $error("result changed while stalled");

endmodule

bind tiled_label_collision_placer tlcp_checker u_tlcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_placed (m_placed),
    .m_status (m_status)
);

`default_nettype wire
